[design/nfsa_pkg.sv]
// Shared types and defaults for the nearest free station allocator.
package nfsa_pkg;

  localparam int NUM_STATIONS_DEF = 64;
  localparam int COORD_BITS_DEF   = 12;
  localparam int CAP_BITS_DEF     = 16;

  localparam int SLOT_BITS   = 6;
  localparam int CFG_BITS    = 7;
  localparam int OUT_IDX_BITS = 6;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_SUM,
    ST_INJECT,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_t;

  // Broadcast command from the controller to every cell.
  typedef struct packed {
    logic load;   // write entry at sel_idx, clear its fill
    logic inc;    // bump fill of entry at sel_idx
  } cell_cmd_t;

endpackage

[design/nfsa_cell.sv]
// One station entry: holds position, capacity and fill, scores the broadcast position.
module nfsa_cell #(
  parameter int CELL_IDX   = 0,
  parameter int IDX_BITS   = 6,
  parameter int COORD_BITS = nfsa_pkg::COORD_BITS_DEF,
  parameter int CAP_BITS   = nfsa_pkg::CAP_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  nfsa_pkg::cell_cmd_t       cmd,
  input  logic [IDX_BITS-1:0]       sel_idx,
  input  logic [COORD_BITS-1:0]     pos_x,
  input  logic [COORD_BITS-1:0]     pos_y,
  input  logic [CAP_BITS-1:0]       cap_in,
  input  logic [nfsa_pkg::CFG_BITS-1:0] cfg_active,
  input  logic                      tok_in_valid,
  input  logic                      tok_in_found,
  input  logic [2*COORD_BITS:0]     tok_in_dist,
  input  logic [IDX_BITS-1:0]       tok_in_idx,
  output logic                      tok_out_valid,
  output logic                      tok_out_found,
  output logic [2*COORD_BITS:0]     tok_out_dist,
  output logic [IDX_BITS-1:0]       tok_out_idx
);

  localparam int SQ_BITS   = 2 * COORD_BITS;
  localparam int DIST_BITS = 2 * COORD_BITS + 1;
  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

  logic [COORD_BITS-1:0] row_r, col_r;
  logic [CAP_BITS-1:0]   cap_r, fill_r;
  logic [SQ_BITS-1:0]    sqx_r, sqy_r;
  logic [DIST_BITS-1:0]  dist_r;

  logic                  tok_valid_r, tok_found_r;
  logic [DIST_BITS-1:0]  tok_dist_r;
  logic [IDX_BITS-1:0]   tok_idx_r;

  logic [COORD_BITS-1:0] dx, dy;
  logic                  hit, active, has_room, take;

  always_comb begin
    dx       = (row_r >= pos_x) ? (row_r - pos_x) : (pos_x - row_r);
    dy       = (col_r >= pos_y) ? (col_r - pos_y) : (pos_y - col_r);
    hit      = (sel_idx == MY_IDX);
    active   = (CELL_IDX < 32'(cfg_active));
    has_room = (fill_r < cap_r);
    take     = tok_in_valid && active && has_room &&
               (!tok_in_found || (dist_r < tok_in_dist));
  end

  // entry payload, no reset: undefined until loaded
  always_ff @(posedge clk) begin
    if (cmd.load && hit) begin
      row_r <= pos_x;
      col_r <= pos_y;
      cap_r <= cap_in;
    end
    sqx_r  <= SQ_BITS'(dx) * SQ_BITS'(dx);
    sqy_r  <= SQ_BITS'(dy) * SQ_BITS'(dy);
    dist_r <= DIST_BITS'(sqx_r) + DIST_BITS'(sqy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.load && hit) begin
      fill_r <= '0;
    end else if (cmd.inc && hit) begin
      fill_r <= fill_r + CAP_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_found_r <= tok_in_found | take;
    tok_dist_r  <= take ? dist_r : tok_in_dist;
    tok_idx_r   <= take ? MY_IDX : tok_in_idx;
  end

  assign tok_out_valid = tok_valid_r;
  assign tok_out_found = tok_found_r;
  assign tok_out_dist  = tok_dist_r;
  assign tok_out_idx   = tok_idx_r;

endmodule

[design/nearest_free_station_allocator_core.sv]
// Top level: controller, configuration register and the chain of station cells.
//
//  channel | dir | handshake                  | payload
//  in_     | in  | in_tvalid / in_tready      | tuser: kind; tdata: slot, capacity, pos_x, pos_y
//  out_    | out | out_tvalid / out_tready    | tuser: allocated; tdata: station_index
//  cfg_    | in  | cfg_we                     | cfg_wdata: active_stations
//
// A load is written into its cell as it is accepted. For a request, the ST_SQR and ST_SUM states
// square and sum the distance in every cell, then a search token walks the cell
// chain one cell per cycle, then ST_UPDATE updates the fill count and ST_RESP
// registers the result once the output is free. A request while exhausted goes straight to ST_RESP.
// Synchronous active-low reset clears fill counts, exhausted and the register.
// Input is held off while a request is in flight or its result cannot be placed.
module nearest_free_station_allocator_core #(
  parameter int NUM_STATIONS = nfsa_pkg::NUM_STATIONS_DEF,
  parameter int COORD_BITS   = nfsa_pkg::COORD_BITS_DEF,
  parameter int CAP_BITS     = nfsa_pkg::CAP_BITS_DEF,
  localparam int IN_BITS     = nfsa_pkg::SLOT_BITS + CAP_BITS + 2 * COORD_BITS,
  localparam int IN_W        = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [IN_W-1:0]               in_tdata,  // station_slot, capacity, pos_x, pos_y
  input  logic                          in_tuser,  // kind
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata, // station_index
  output logic                          out_tuser, // allocated
  input  logic                          cfg_we,
  input  logic [nfsa_pkg::CFG_BITS-1:0] cfg_wdata
);

  localparam int IDX_BITS  = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;
  localparam int DIST_BITS = 2 * COORD_BITS + 1;
  localparam int CAP_LO    = nfsa_pkg::SLOT_BITS;
  localparam int X_LO      = CAP_LO + CAP_BITS;
  localparam int Y_LO      = X_LO + COORD_BITS;

  nfsa_pkg::state_t    state_r, state_nxt;
  nfsa_pkg::cell_cmd_t cmd;

  logic [nfsa_pkg::CFG_BITS-1:0] active_r;
  logic                          exhausted_r;
  logic [COORD_BITS-1:0]         px_r, py_r;
  logic                          res_alloc_r;
  logic [IDX_BITS-1:0]           res_idx_r;
  logic                          out_valid_r, out_alloc_r;
  logic [nfsa_pkg::OUT_IDX_BITS-1:0] out_idx_r;

  logic [nfsa_pkg::SLOT_BITS-1:0] in_slot;
  logic [CAP_BITS-1:0]            in_cap;
  logic [COORD_BITS-1:0]          in_x, in_y, bus_x, bus_y;
  logic                           in_xfer, slot_ok, out_free;
  logic [IDX_BITS-1:0]            sel_idx;

  logic                 tok_valid [NUM_STATIONS+1];
  logic                 tok_found [NUM_STATIONS+1];
  logic [DIST_BITS-1:0] tok_dist  [NUM_STATIONS+1];
  logic [IDX_BITS-1:0]  tok_idx   [NUM_STATIONS+1];

  assign in_slot  = in_tdata[nfsa_pkg::SLOT_BITS-1:0];
  assign in_cap   = in_tdata[X_LO-1:CAP_LO];
  assign in_x     = in_tdata[Y_LO-1:X_LO];
  assign in_y     = in_tdata[IN_BITS-1:Y_LO];
  assign in_xfer  = in_tvalid && in_tready;
  assign slot_ok  = (32'(in_slot) < NUM_STATIONS);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nfsa_pkg::ST_IDLE: begin
        if (in_tvalid && in_tuser == nfsa_pkg::KIND_REQUEST) begin
          state_nxt = exhausted_r ? nfsa_pkg::ST_RESP : nfsa_pkg::ST_SQR;
        end
      end
      nfsa_pkg::ST_SQR:    state_nxt = nfsa_pkg::ST_SUM;
      nfsa_pkg::ST_SUM:    state_nxt = nfsa_pkg::ST_INJECT;
      nfsa_pkg::ST_INJECT: state_nxt = nfsa_pkg::ST_SCAN;
      nfsa_pkg::ST_SCAN: begin
        if (tok_valid[NUM_STATIONS]) begin
          state_nxt = nfsa_pkg::ST_UPDATE;
        end
      end
      nfsa_pkg::ST_UPDATE: state_nxt = nfsa_pkg::ST_RESP;
      nfsa_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = nfsa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nfsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = (state_r == nfsa_pkg::ST_IDLE);
    cmd.load     = in_xfer && (in_tuser == nfsa_pkg::KIND_LOAD) && slot_ok;
    cmd.inc      = (state_r == nfsa_pkg::ST_UPDATE) && res_alloc_r;
    sel_idx      = (state_r == nfsa_pkg::ST_UPDATE) ? res_idx_r : IDX_BITS'(in_slot);
    // loads drive the cells straight from the bus, requests from the held position
    bus_x        = (state_r == nfsa_pkg::ST_IDLE) ? in_x : px_r;
    bus_y        = (state_r == nfsa_pkg::ST_IDLE) ? in_y : py_r;
    tok_valid[0] = (state_r == nfsa_pkg::ST_INJECT);
    tok_found[0] = 1'b0;
    tok_dist[0]  = '0;
    tok_idx[0]   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfsa_pkg::ST_IDLE;
      active_r    <= '0;
      exhausted_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        active_r <= cfg_wdata;
      end
      if (cmd.load) begin
        exhausted_r <= 1'b0;
      end else if (state_r == nfsa_pkg::ST_UPDATE && !res_alloc_r) begin
        exhausted_r <= 1'b1;
      end
      if (state_r == nfsa_pkg::ST_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_tuser == nfsa_pkg::KIND_REQUEST) begin
      px_r        <= in_x;
      py_r        <= in_y;
      res_alloc_r <= 1'b0;
      res_idx_r   <= '0;
    end else if (state_r == nfsa_pkg::ST_SCAN && tok_valid[NUM_STATIONS]) begin
      res_alloc_r <= tok_found[NUM_STATIONS];
      res_idx_r   <= tok_found[NUM_STATIONS] ? tok_idx[NUM_STATIONS] : '0;
    end
    if (state_r == nfsa_pkg::ST_RESP && out_free) begin
      out_alloc_r <= res_alloc_r;
      out_idx_r   <= nfsa_pkg::OUT_IDX_BITS'(res_idx_r);
    end
  end

  for (genvar i = 0; i < NUM_STATIONS; i++) begin : g_cell
    nfsa_cell #(
      .CELL_IDX   (i),
      .IDX_BITS   (IDX_BITS),
      .COORD_BITS (COORD_BITS),
      .CAP_BITS   (CAP_BITS)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .cmd           (cmd),
      .sel_idx       (sel_idx),
      .pos_x         (bus_x),
      .pos_y         (bus_y),
      .cap_in        (in_cap),
      .cfg_active    (active_r),
      .tok_in_valid  (tok_valid[i]),
      .tok_in_found  (tok_found[i]),
      .tok_in_dist   (tok_dist[i]),
      .tok_in_idx    (tok_idx[i]),
      .tok_out_valid (tok_valid[i+1]),
      .tok_out_found (tok_found[i+1]),
      .tok_out_dist  (tok_dist[i+1]),
      .tok_out_idx   (tok_idx[i+1])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_alloc_r;
  assign out_tdata  = 8'(out_idx_r);

endmodule
